@@ src/bsfr_pkg.sv @@
// Shared types and constants for the byte stream find-and-replace block.
`timescale 1ns / 1ps

package bsfr_pkg;

  // Field and register widths
  localparam int ByteW    = 8;
  localparam int LenW     = 4;
  localparam int DataW    = 64;
  localparam int CfgIdxW  = 4;
  localparam int WinMax   = 8;
  localparam int JobDepth = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPatBytes  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPatLen    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegReplBytes = 4'd2;
  localparam logic [CfgIdxW-1:0] RegReplLen   = 4'd3;

  // Next-value select for one window cell
  typedef enum logic [1:0] {
    CellHold     = 2'd0,
    CellShift1   = 2'd1,
    CellShiftLen = 2'd2
  } cell_op_e;

  // Control broadcast to every window cell
  typedef struct packed {
    logic            en;
    cell_op_e        op;
    logic [LenW-1:0] fill;
  } cell_ctl_t;

  // Results caused by one item, waiting to be drained
  typedef struct packed {
    logic [LenW-1:0]                cnt;
    logic                           mark;
    logic                           last;
    logic [JobDepth-1:0][ByteW-1:0] bytes;
  } job_t;

endpackage

@@ src/bsfr_win_cell.sv @@
// One window cell: holds a pending byte and compares it with its pattern byte.
`timescale 1ns / 1ps

module bsfr_win_cell #(
  parameter int Index = 0
) (
  input  logic                       clk_i,
  input  logic [bsfr_pkg::ByteW-1:0] in_byte_i,
  input  logic [bsfr_pkg::ByteW-1:0] pat_byte_i,
  input  bsfr_pkg::cell_ctl_t        ctl_i,
  input  logic [bsfr_pkg::ByteW-1:0] next_i,
  input  logic [bsfr_pkg::ByteW-1:0] far_i,
  output logic [bsfr_pkg::ByteW-1:0] ext_o,
  output logic                       eq_o
);

  logic [bsfr_pkg::ByteW-1:0] byte_q;
  logic [bsfr_pkg::ByteW-1:0] byte_d;

  // Take the incoming byte when this cell is the append slot
  assign ext_o = (ctl_i.fill == bsfr_pkg::LenW'(Index)) ? in_byte_i : byte_q;
  assign eq_o  = (ext_o == pat_byte_i);

  // Select the next content: own byte, neighbor, or the byte a pattern length on
  always_comb begin
    byte_d = byte_q;
    if (ctl_i.en) begin
      case (ctl_i.op)
        bsfr_pkg::CellHold:     byte_d = ext_o;
        bsfr_pkg::CellShift1:   byte_d = next_i;
        bsfr_pkg::CellShiftLen: byte_d = far_i;
        default:                byte_d = byte_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

@@ src/bsfr_emit.sv @@
// Result drain: holds one item's results, sends one per cycle unless stalled.
`timescale 1ns / 1ps

module bsfr_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bsfr_pkg::job_t             job_i,
  input  logic                       load_i,
  output logic                       ready_o,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic [bsfr_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_valid_o,
  output logic                       out_last_o
);

  bsfr_pkg::job_t             job_q, job_d;
  logic                       ovld_q, ovld_d;
  logic [bsfr_pkg::ByteW-1:0] obyte_q, obyte_d;
  logic                       oflag_q, oflag_d;
  logic                       olast_q, olast_d;
  logic                       out_free;
  logic                       take;

  assign out_free = !ovld_q || !res_stall_i;
  assign take     = out_free && (job_q.cnt != '0);
  assign ready_o  = (job_q.cnt == '0) ||
                    ((job_q.cnt == bsfr_pkg::LenW'(1)) && out_free);

  // Move the front result into the output register, shift the rest forward
  always_comb begin
    job_d   = job_q;
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    oflag_d = oflag_q;
    olast_d = olast_q;
    if (out_free) begin
      ovld_d = take;
    end
    if (take) begin
      obyte_d = job_q.mark ? '0 : job_q.bytes[0];
      oflag_d = !job_q.mark;
      olast_d = job_q.last && (job_q.cnt == bsfr_pkg::LenW'(1));
    end
    if (load_i) begin
      job_d = job_i;
    end else if (take) begin
      job_d.cnt = job_q.cnt - bsfr_pkg::LenW'(1);
      for (int k = 0; k < bsfr_pkg::JobDepth - 1; k++) begin
        job_d.bytes[k] = job_q.bytes[k+1];
      end
      job_d.bytes[bsfr_pkg::JobDepth-1] = '0;
    end
  end

  // Control state and pending results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      job_q  <= job_d;
      ovld_q <= ovld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    oflag_q <= oflag_d;
    olast_q <= olast_d;
  end

  assign res_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign out_valid_o = oflag_q;
  assign out_last_o  = olast_q;

endmodule

@@ src/byte_stream_find_replace.sv @@
// Top level of the byte stream find-and-replace block.
`timescale 1ns / 1ps

// Replaces every leftmost, non-overlapping occurrence of the configured pattern
// (1 to 8 bytes) in a byte text with the configured replacement (0 to 8 bytes).
// Pending bytes sit in a row of cells, one byte per cell, each comparing its
// byte with its pattern byte; the row shifts toward the front as bytes leave.
// An item with zero or one result is taken every cycle unless the output
// stalls; one with more holds the input until its last result is taken, as the
// output register drains one result per cycle while not stalled.
// No clearing pass follows reset. Write configuration only while idle.
module byte_stream_find_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bsfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bsfr_pkg::DataW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bsfr_pkg::ByteW-1:0]   in_byte_i,
  input  logic                         in_last_i,
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output logic [bsfr_pkg::ByteW-1:0]   out_byte_o,
  output logic                         out_valid_o,
  output logic                         out_last_o
);

  localparam int WinDepth = (MAX_PATTERN < bsfr_pkg::WinMax) ? MAX_PATTERN
                                                             : bsfr_pkg::WinMax;
  localparam int FillW    = $clog2(WinDepth + 1);

  logic [bsfr_pkg::DataW-1:0] pat_q;
  logic [bsfr_pkg::LenW-1:0]  pat_len_q;
  logic [bsfr_pkg::DataW-1:0] repl_q;
  logic [bsfr_pkg::LenW-1:0]  repl_len_q;
  logic [FillW-1:0]           fill_q, fill_d;

  logic [WinDepth-1:0][bsfr_pkg::ByteW-1:0] ext;
  logic [WinDepth-1:0][bsfr_pkg::ByteW-1:0] nxt;
  logic [WinDepth-1:0][bsfr_pkg::ByteW-1:0] far;
  logic [WinDepth-1:0]                      eq;

  bsfr_pkg::cell_ctl_t       ctl;
  bsfr_pkg::job_t            job;
  logic                      ready;
  logic                      accept;
  logic [bsfr_pkg::LenW-1:0] len;
  logic [bsfr_pkg::LenW-1:0] rlen;
  logic [bsfr_pkg::LenW-1:0] fill_ext;
  logic                      full;
  logic                      all_eq;
  logic                      hit;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      pat_len_q  <= bsfr_pkg::LenW'(1);
      repl_q     <= '0;
      repl_len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsfr_pkg::RegPatBytes:  pat_q      <= cfg_data_i;
        bsfr_pkg::RegPatLen:    pat_len_q  <= cfg_data_i[bsfr_pkg::LenW-1:0];
        bsfr_pkg::RegReplBytes: repl_q     <= cfg_data_i;
        bsfr_pkg::RegReplLen:   repl_len_q <= cfg_data_i[bsfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the lengths in use
  always_comb begin
    len = pat_len_q;
    if (len == '0) begin
      len = bsfr_pkg::LenW'(1);
    end
    if (len > bsfr_pkg::LenW'(WinDepth)) begin
      len = bsfr_pkg::LenW'(WinDepth);
    end
    rlen = (repl_len_q > bsfr_pkg::LenW'(8)) ? bsfr_pkg::LenW'(8) : repl_len_q;
  end

  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;
  assign fill_ext   = bsfr_pkg::LenW'(fill_q) + bsfr_pkg::LenW'(1);
  assign full       = (fill_ext >= len);

  // Front of the window against the pattern
  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < WinDepth; i++) begin
      if (bsfr_pkg::LenW'(i) < len && !eq[i]) begin
        all_eq = 1'b0;
      end
    end
  end

  assign hit = full && all_eq && (!in_last_i || fill_ext == len);

  // Byte a pattern length further on, for the shift after a match
  always_comb begin
    for (int i = 0; i < WinDepth; i++) begin
      far[i] = '0;
      for (int k = 0; k < WinDepth; k++) begin
        if (int'(len) + i == k) begin
          far[i] = ext[k];
        end
      end
    end
  end

  // Window update and fill count
  always_comb begin
    ctl.en   = accept;
    ctl.op   = bsfr_pkg::CellHold;
    ctl.fill = bsfr_pkg::LenW'(fill_q);
    fill_d   = fill_q;
    if (accept) begin
      if (in_last_i) begin
        fill_d = '0;
      end else if (full && all_eq) begin
        ctl.op = bsfr_pkg::CellShiftLen;
        fill_d = FillW'(fill_ext - len);
      end else if (full) begin
        ctl.op = bsfr_pkg::CellShift1;
        fill_d = FillW'(fill_ext - bsfr_pkg::LenW'(1));
      end else begin
        fill_d = FillW'(fill_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Row of window cells
  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    if (i == WinDepth - 1) begin : g_tail
      assign nxt[i] = '0;
    end else begin : g_body
      assign nxt[i] = ext[i+1];
    end

    bsfr_win_cell #(
      .Index(i)
    ) u_cell (
      .clk_i      (clk_i),
      .in_byte_i  (in_byte_i),
      .pat_byte_i (pat_q[bsfr_pkg::ByteW*i +: bsfr_pkg::ByteW]),
      .ctl_i      (ctl),
      .next_i     (nxt[i]),
      .far_i      (far[i]),
      .ext_o      (ext[i]),
      .eq_o       (eq[i])
    );
  end

  // Results of this item: replacement, flushed window, one byte or none
  always_comb begin
    for (int k = 0; k < bsfr_pkg::JobDepth; k++) begin
      if (hit) begin
        job.bytes[k] = repl_q[bsfr_pkg::ByteW*k +: bsfr_pkg::ByteW];
      end else if (k < WinDepth) begin
        job.bytes[k] = ext[k];
      end else begin
        job.bytes[k] = '0;
      end
    end
    job.last = in_last_i;
    if (hit) begin
      job.cnt = rlen;
    end else if (in_last_i) begin
      job.cnt = fill_ext;
    end else if (full) begin
      job.cnt = bsfr_pkg::LenW'(1);
    end else begin
      job.cnt = '0;
    end
    job.mark = in_last_i && (job.cnt == '0);
    if (job.mark) begin
      job.cnt = bsfr_pkg::LenW'(1);
    end
  end

  bsfr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .load_i      (accept),
    .ready_o     (ready),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o)
  );

endmodule
